### design/tlvfx_pkg.sv
// Shared types and constants for the TLV field value extractor.
package tlvfx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CauseW = 2;

  // Scan phase of the option parser
  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  // End cause codes reported with each result
  typedef enum logic [CauseW-1:0] {
    CAUSE_FOUND     = 2'd0,
    CAUSE_END_LIST  = 2'd1,
    CAUSE_BAD_LEN   = 2'd2,
    CAUSE_EXHAUSTED = 2'd3
  } cause_t;

  localparam logic [ByteW-1:0] TargetReset = 8'd1;
  localparam logic [ByteW-1:0] EndOfList   = 8'd0;

endpackage

### design/tlv_field_value_extractor.sv
// Top level of the TLV field value extractor: byte register, parser and result register.
//
//   Channel | Direction | Ports                                          | Meaning
//   in_     | input     | in_valid/in_ready, in_data_byte,               | one packet byte
//           |           | in_packet_length, in_first_byte                |
//   out_    | output    | out_valid/out_ready, out_field_value,          | one result per packet
//           |           | out_end_cause                                  |
//   cfg_    | input     | cfg_valid/cfg_ready, cfg_target_type           | target option type
//
// One byte per cycle while out_ready does not hold the flow: a byte sits in
// the input register, the parser step runs on it and a result lands in the
// output register on the next edge, where it shows on out_valid.
// Reset (rst_n low, synchronous) empties both registers, restarts the scan at
// a type byte and sets the target type to 1. When out_ready is low with a
// result waiting, the input register holds and in_ready drops.
module tlv_field_value_extractor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tlvfx_pkg::ByteW-1:0]     in_data_byte,
  input  logic [tlvfx_pkg::LenW-1:0]      in_packet_length,
  input  logic                            in_first_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tlvfx_pkg::ValueW-1:0]    out_field_value,
  output logic [tlvfx_pkg::CauseW-1:0]    out_end_cause,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlvfx_pkg::ByteW-1:0]     cfg_target_type
);
  import tlvfx_pkg::*;

  // configuration register
  logic [ByteW-1:0] target_r;

  // input byte register
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic [LenW-1:0]  s1_plen_r;
  logic             s1_first_r;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic [LenW-1:0]   pos_r, pos_nxt;
  logic [ByteW-1:0]  left_r, left_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;
  logic              tgt_r, tgt_nxt;

  // output register
  logic              out_valid_r;
  logic [ValueW-1:0] out_value_r;
  cause_t            out_cause_r;

  logic out_free;
  logic s1_go;

  // effective state after a first-byte restart
  phase_t          phase_eff;
  logic [LenW-1:0] pos_eff;
  logic [LenW:0]   pos_p1;
  logic [LenW+1:0] opt_end;
  logic [ByteW-1:0] left_dec;
  logic [ValueW-1:0] acc_shift;

  // step decode
  logic   emit;
  logic [ValueW-1:0] emit_value;
  cause_t emit_cause;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || s1_go;

  assign phase_eff = s1_first_r ? PH_TYPE : phase_r;
  assign pos_eff   = s1_first_r ? '0 : pos_r;
  assign pos_p1    = {1'b0, pos_eff} + (LenW+1)'(1);
  assign opt_end   = {1'b0, pos_p1} + (LenW+2)'(s1_byte_r);
  assign left_dec  = left_r - ByteW'(1);
  assign acc_shift = {acc_r[ValueW-ByteW-1:0], s1_byte_r};

  // next-state logic of the parser
  always_comb begin
    phase_nxt = phase_eff;
    pos_nxt   = pos_eff;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    tgt_nxt   = s1_first_r ? 1'b0 : tgt_r;
    if (phase_eff != PH_DONE) begin
      pos_nxt = pos_p1[LenW-1:0];
    end
    case (phase_eff)
      PH_TYPE: begin
        if ({1'b0, pos_eff} >= {1'b0, s1_plen_r} || s1_byte_r == EndOfList ||
            pos_p1 >= {1'b0, s1_plen_r}) begin
          phase_nxt = PH_DONE;
        end else begin
          tgt_nxt   = (s1_byte_r == target_r);
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (opt_end >= {2'b00, s1_plen_r}) begin
          phase_nxt = PH_DONE;
        end else if (s1_byte_r == '0) begin
          phase_nxt = tgt_nxt ? PH_DONE : PH_TYPE;
        end else begin
          left_nxt  = s1_byte_r;
          acc_nxt   = '0;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        acc_nxt  = acc_shift;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = tgt_r ? PH_DONE : PH_TYPE;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  // result decode of the parser
  always_comb begin
    emit       = 1'b0;
    emit_value = '0;
    emit_cause = CAUSE_FOUND;
    case (phase_eff)
      PH_TYPE: begin
        if ({1'b0, pos_eff} >= {1'b0, s1_plen_r}) begin
          emit       = 1'b1;
          emit_cause = CAUSE_EXHAUSTED;
        end else if (s1_byte_r == EndOfList) begin
          emit       = 1'b1;
          emit_cause = CAUSE_END_LIST;
        end else if (pos_p1 >= {1'b0, s1_plen_r}) begin
          emit       = 1'b1;
          emit_cause = CAUSE_EXHAUSTED;
        end
      end
      PH_LEN: begin
        if (opt_end >= {2'b00, s1_plen_r}) begin
          emit       = 1'b1;
          emit_cause = CAUSE_BAD_LEN;
        end else if (s1_byte_r == '0 && tgt_nxt) begin
          emit = 1'b1;
        end
      end
      PH_VALUE: begin
        if (left_dec == '0 && tgt_r) begin
          emit       = 1'b1;
          emit_value = acc_shift;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TargetReset;
    end else if (cfg_valid && cfg_ready) begin
      target_r <= cfg_target_type;
    end
  end

  // input byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_data_byte;
      s1_plen_r  <= in_packet_length;
      s1_first_r <= in_first_byte;
    end
  end

  // parser state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      pos_r   <= '0;
      left_r  <= '0;
      acc_r   <= '0;
      tgt_r   <= 1'b0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      tgt_r   <= tgt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_value_r <= emit_value;
      out_cause_r <= emit_cause;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_value = out_value_r;
  assign out_end_cause   = out_cause_r;

endmodule

### design/tlvfx_checker.sv
// Port-level checks for the TLV field value extractor, bound to the top level.
module tlvfx_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tlvfx_pkg::ValueW-1:0]    out_field_value,
  input logic [tlvfx_pkg::CauseW-1:0]    out_end_cause
);
  import tlvfx_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_field_value) &&
    $stable(out_end_cause))
    else $error("result changed while stalled");

  // only a found option carries a nonzero value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_cause != CAUSE_FOUND |-> out_field_value == '0)
    else $error("nonzero value with a failure cause");

  // with the output register empty, a request is never refused
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tlv_field_value_extractor tlvfx_checker u_tlvfx_checker (.*);
